// File: src/dwfr_pkg.sv
// ---------------------------------------------------------------------------
// dwfr_pkg
// shared widths, constants and the request/response types of the chunk unit
// ---------------------------------------------------------------------------
package dwfr_pkg;

  localparam int ROOT_W    = 32;
  localparam int HALF_W    = 5;
  localparam int POS_W     = 5;
  localparam int RANK_W    = 5;
  localparam int CHUNK_W   = 8;
  localparam int OFS_W     = 3;
  localparam int POP_W     = 4;
  // heights and counts cover words of up to 63 steps
  localparam int HGT_W     = 7;
  localparam int CNT_W     = 7;

  localparam logic [HALF_W-1:0] HALF_RESET = 5'd8;

  typedef struct packed {
    logic [CHUNK_W-1:0]       bits;
    logic [CHUNK_W-1:0]       mask;
    logic signed [HGT_W-1:0]  h;
    logic                     is_del;
    logic [POP_W-1:0]         rank;
  } chunk_req_t;

  typedef struct packed {
    logic signed [HGT_W-1:0]  h_next;
    logic [CHUNK_W-1:0]       qual;
    logic [POP_W-1:0]         hits;
    logic [POP_W-1:0]         pop;
    logic                     found;
    logic [OFS_W-1:0]         ofs;
  } chunk_res_t;

endpackage

// File: src/dyck_word_flip_rank_chain.sv
// ---------------------------------------------------------------------------
// dyck_word_flip_rank_chain
// runs up to m insert/delete rounds on a step word and reports each round
// ---------------------------------------------------------------------------
// Usage: the input channel (in_valid_i / in_stall_o) takes one root word; bit i
// is step i, 1 up and 0 down. half_length (m) is written through cfg_we_i /
// cfg_wdata_i; the user must write it only while the block is idle, which the
// block does not enforce; 0 acts as 1, values above MAX_HALF_LENGTH saturate.
// Each input gives up to m results on the output channel (out_valid_o /
// out_stall_i), one per round in order, with last set on the final one; a round
// that finds no match reports fault and ends the run. Timing: one 8-step chunk
// unit is shared by every pass. A map is a counting pass over the chunks of the
// word and a select pass over at most as many chunks; a round is an insert map,
// a delete map and the output state. in_stall_o is high from the transfer of a
// word until its last result has been taken.
// Reset: the block goes idle and half_length returns to 8. While the receiver
// stalls, the result register holds and the sequencer waits.
// ---------------------------------------------------------------------------
module dyck_word_flip_rank_chain #(
  parameter int MAX_HALF_LENGTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dwfr_pkg::HALF_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dwfr_pkg::ROOT_W-1:0]   root_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dwfr_pkg::POS_W-1:0]    insert_position_o,
  output logic [dwfr_pkg::POS_W-1:0]    delete_position_o,
  output logic [dwfr_pkg::RANK_W-1:0]   round_rank_o,
  output logic                          fault_o,
  output logic                          last_o
);

  localparam int NCH  = (2 * MAX_HALF_LENGTH + dwfr_pkg::CHUNK_W - 1) / dwfr_pkg::CHUNK_W;
  localparam int CIW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int WP   = (1 << CIW) * dwfr_pkg::CHUNK_W;
  localparam int GIW  = CIW + dwfr_pkg::OFS_W;
  localparam int LENW = GIW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CNT  = 2'd1;
  localparam logic [1:0] S_SEL  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                        state_q, state_d;
  logic [dwfr_pkg::HALF_W-1:0]       half_q;
  logic [WP-1:0]                     word_q, word_d;
  logic [WP-1:0]                     qual_q, qual_d;
  logic [dwfr_pkg::HALF_W-1:0]       m_q, m_d;
  logic [LENW-1:0]                   len_q, len_d;
  logic [CIW-1:0]                    last_ci_q, last_ci_d;
  logic [CIW-1:0]                    ci_q, ci_d;
  logic                              del_q, del_d;
  logic signed [dwfr_pkg::HGT_W-1:0] h_q, h_d;
  logic [dwfr_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic [dwfr_pkg::CNT_W-1:0]        seen_q, seen_d;
  logic [GIW-1:0]                    ins_pos_q, ins_pos_d;
  logic [dwfr_pkg::RANK_W-1:0]       round_q, round_d;
  logic [dwfr_pkg::POS_W-1:0]        o_ins_q, o_ins_d;
  logic [dwfr_pkg::POS_W-1:0]        o_del_q, o_del_d;
  logic [dwfr_pkg::RANK_W-1:0]       o_rank_q, o_rank_d;
  logic                              o_fault_q, o_fault_d;
  logic                              o_last_q, o_last_d;

  dwfr_pkg::chunk_req_t              req;
  dwfr_pkg::chunk_res_t              res;

  logic [dwfr_pkg::HALF_W-1:0]       m_sat;
  logic [dwfr_pkg::HALF_W:0]         nch_m;
  logic [dwfr_pkg::CHUNK_W-1:0]      mask;
  logic [GIW-1:0]                    gidx;
  logic [dwfr_pkg::CNT_W-1:0]        tgt;
  logic [dwfr_pkg::CNT_W-1:0]        diff;
  logic [GIW-1:0]                    pos;
  logic [dwfr_pkg::RANK_W-1:0]       rank_next;

  // saturated round count and chunk count for a new word
  always_comb begin
    if (half_q == '0) begin
      m_sat = dwfr_pkg::HALF_W'(1);
    end else if (half_q > dwfr_pkg::HALF_W'(MAX_HALF_LENGTH)) begin
      m_sat = dwfr_pkg::HALF_W'(MAX_HALF_LENGTH);
    end else begin
      m_sat = half_q;
    end
    nch_m = ({1'b0, m_sat} + (dwfr_pkg::HALF_W + 1)'(3)) >> 2;
  end

  // steps past the word length take no part
  always_comb begin
    mask = '0;
    gidx = '0;
    for (int k = 0; k < dwfr_pkg::CHUNK_W; k++) begin
      gidx    = {ci_q, dwfr_pkg::OFS_W'(k)};
      mask[k] = LENW'(gidx) < len_q;
    end
  end

  always_comb begin
    tgt = del_q ? cnt_q : (cnt_q + 1'b1);
    diff = tgt - seen_q;
    req.mask   = mask;
    req.h      = h_q;
    req.is_del = del_q;
    if (state_q == S_SEL) begin
      req.bits = qual_q[{ci_q, dwfr_pkg::OFS_W'(0)} +: dwfr_pkg::CHUNK_W];
      req.rank = ((tgt > seen_q) && (diff <= dwfr_pkg::CNT_W'(dwfr_pkg::CHUNK_W))) ?
                 dwfr_pkg::POP_W'(diff) : '0;
    end else begin
      req.bits = word_q[{ci_q, dwfr_pkg::OFS_W'(0)} +: dwfr_pkg::CHUNK_W];
      req.rank = '0;
    end
  end

  dwfr_chunk u_chunk (
    .req_i (req),
    .res_o (res)
  );

  always_comb begin
    state_d   = state_q;
    word_d    = word_q;
    qual_d    = qual_q;
    m_d       = m_q;
    len_d     = len_q;
    last_ci_d = last_ci_q;
    ci_d      = ci_q;
    del_d     = del_q;
    h_d       = h_q;
    cnt_d     = cnt_q;
    seen_d    = seen_q;
    ins_pos_d = ins_pos_q;
    round_d   = round_q;
    o_ins_d   = o_ins_q;
    o_del_d   = o_del_q;
    o_rank_d  = o_rank_q;
    o_fault_d = o_fault_q;
    o_last_d  = o_last_q;
    pos       = {ci_q, res.ofs};
    rank_next = round_q + 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          word_d    = WP'(root_word_i);
          m_d       = m_sat;
          len_d     = LENW'({m_sat, 1'b0});
          last_ci_d = CIW'(nch_m - 1'b1);
          ci_d      = '0;
          del_d     = 1'b0;
          h_d       = '0;
          cnt_d     = '0;
          round_d   = '0;
          state_d   = S_CNT;
        end
      end
      S_CNT: begin
        qual_d[{ci_q, dwfr_pkg::OFS_W'(0)} +: dwfr_pkg::CHUNK_W] = res.qual;
        cnt_d = cnt_q + dwfr_pkg::CNT_W'(res.hits);
        h_d   = res.h_next;
        if (ci_q == last_ci_q) begin
          ci_d    = '0;
          seen_d  = '0;
          state_d = S_SEL;
        end else begin
          ci_d = ci_q + 1'b1;
        end
      end
      S_SEL: begin
        if (res.found) begin
          ci_d  = '0;
          h_d   = '0;
          cnt_d = '0;
          if (!del_q) begin
            word_d[pos] = 1'b1;
            ins_pos_d   = pos;
            del_d       = 1'b1;
            state_d     = S_CNT;
          end else begin
            word_d[pos] = 1'b0;
            o_ins_d     = dwfr_pkg::POS_W'(ins_pos_q);
            o_del_d     = dwfr_pkg::POS_W'(pos);
            o_rank_d    = rank_next;
            o_fault_d   = 1'b0;
            o_last_d    = (rank_next == m_q);
            state_d     = S_OUT;
          end
        end else if (ci_q == last_ci_q) begin
          // no match in this map: fault ends the run
          o_ins_d   = del_q ? dwfr_pkg::POS_W'(ins_pos_q) : '0;
          o_del_d   = '0;
          o_rank_d  = rank_next;
          o_fault_d = 1'b1;
          o_last_d  = 1'b1;
          state_d   = S_OUT;
        end else begin
          ci_d   = ci_q + 1'b1;
          seen_d = seen_q + dwfr_pkg::CNT_W'(res.pop);
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          if (o_last_q) begin
            state_d = S_IDLE;
          end else begin
            round_d = rank_next;
            del_d   = 1'b0;
            ci_d    = '0;
            h_d     = '0;
            cnt_d   = '0;
            state_d = S_CNT;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      half_q  <= dwfr_pkg::HALF_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        half_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q    <= word_d;
    qual_q    <= qual_d;
    m_q       <= m_d;
    len_q     <= len_d;
    last_ci_q <= last_ci_d;
    ci_q      <= ci_d;
    del_q     <= del_d;
    h_q       <= h_d;
    cnt_q     <= cnt_d;
    seen_q    <= seen_d;
    ins_pos_q <= ins_pos_d;
    round_q   <= round_d;
    o_ins_q   <= o_ins_d;
    o_del_q   <= o_del_d;
    o_rank_q  <= o_rank_d;
    o_fault_q <= o_fault_d;
    o_last_q  <= o_last_d;
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = (state_q == S_OUT);
  assign insert_position_o = o_ins_q;
  assign delete_position_o = o_del_q;
  assign round_rank_o      = o_rank_q;
  assign fault_o           = o_fault_q;
  assign last_o            = o_last_q;

endmodule

// File: src/dwfr_chunk.sv
// ---------------------------------------------------------------------------
// dwfr_chunk
// shared step unit: walks one chunk of steps (heights, qualifying steps,
// counted steps) and picks the n-th set bit of the same chunk
// ---------------------------------------------------------------------------
module dwfr_chunk (
  input  dwfr_pkg::chunk_req_t req_i,
  output dwfr_pkg::chunk_res_t res_o
);

  logic signed [dwfr_pkg::HGT_W-1:0] h;
  logic [dwfr_pkg::CHUNK_W-1:0]      qual;
  logic [dwfr_pkg::POP_W-1:0]        hits;
  logic [dwfr_pkg::POP_W-1:0]        pop;
  logic                              found;
  logic [dwfr_pkg::OFS_W-1:0]        ofs;
  logic                              b;
  logic                              lvl;

  always_comb begin
    h     = req_i.h;
    qual  = '0;
    hits  = '0;
    pop   = '0;
    found = 1'b0;
    ofs   = '0;
    b     = 1'b0;
    lvl   = 1'b0;
    for (int k = 0; k < dwfr_pkg::CHUNK_W; k++) begin
      b   = req_i.bits[k];
      lvl = (h == 7'sd0) || (h == 7'sd1);
      if (req_i.mask[k]) begin
        if (req_i.is_del) begin
          qual[k] = b & lvl;
          hits    = hits + dwfr_pkg::POP_W'(b && (h == 7'sd1));
        end else begin
          qual[k] = !b & lvl;
          hits    = hits + dwfr_pkg::POP_W'(!b && (h == 7'sd0));
        end
        if (b) begin
          pop = pop + 1'b1;
          // rank zero never matches
          if (!found && (pop == req_i.rank)) begin
            found = 1'b1;
            ofs   = dwfr_pkg::OFS_W'(k);
          end
        end
      end
      h = b ? (h + 7'sd1) : (h - 7'sd1);
    end
    res_o.h_next = h;
    res_o.qual   = qual;
    res_o.hits   = hits;
    res_o.pop    = pop;
    res_o.found  = found;
    res_o.ofs    = ofs;
  end

endmodule

// File: src/dwfr_checker.sv
// ---------------------------------------------------------------------------
// dwfr_assertions
// port-level checks on the flip rank chain, bound to the top level
// ---------------------------------------------------------------------------
module dwfr_assertions (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [dwfr_pkg::POS_W-1:0]    insert_position_o,
  input logic [dwfr_pkg::POS_W-1:0]    delete_position_o,
  input logic [dwfr_pkg::RANK_W-1:0]   round_rank_o,
  input logic                          fault_o,
  input logic                          last_o
);

  // a waiting result means the run is still open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result shown while input side idle");

  // an input transfer opens a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (in_stall_o && !out_valid_o))
    else $error("block not busy after input transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fault_o) |-> (last_o && (delete_position_o == '0)))
    else $error("fault result not final");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (round_rank_o != '0))
    else $error("round rank zero");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(round_rank_o)
      && $stable(insert_position_o) && $stable(delete_position_o)
      && $stable(fault_o) && $stable(last_o)))
    else $error("stalled result changed");

endmodule

bind dyck_word_flip_rank_chain dwfr_assertions u_dwfr_assertions (.*);

// File: bench/dwfr_checker.sv
// ---------------------------------------------------------------------------
// dwfr_checker
// watches both channels of the flip rank chain, predicts the round reports
// of every accepted root word and compares them in order, field by field
// ---------------------------------------------------------------------------
module dwfr_checker #(
  parameter int MAX_HALF_LENGTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dwfr_pkg::HALF_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [dwfr_pkg::ROOT_W-1:0]   root_word_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [dwfr_pkg::POS_W-1:0]    insert_position_i,
  input  logic [dwfr_pkg::POS_W-1:0]    delete_position_i,
  input  logic [dwfr_pkg::RANK_W-1:0]   round_rank_i,
  input  logic                          fault_i,
  input  logic                          last_i,
  output int                            pending_o,
  output int                            errors_o,
  output int                            rounds_o,
  output int                            faults_o
);

  typedef struct packed {
    logic [dwfr_pkg::POS_W-1:0]  ins_pos;
    logic [dwfr_pkg::POS_W-1:0]  del_pos;
    logic [dwfr_pkg::RANK_W-1:0] rank;
    logic                        fault;
    logic                        last;
  } round_rep_t;

  round_rep_t                  expected_rounds[$];
  round_rep_t                  want;
  logic [dwfr_pkg::HALF_W-1:0] half_cfg;
  int                          mismatches  = 0;
  int                          rounds_seen = 0;
  int                          faults_seen = 0;

  assign errors_o = mismatches;
  assign rounds_o = rounds_seen;
  assign faults_o = faults_seen;

  // (count of downs from height 0)+1 -th down step starting at height 0 or 1
  function automatic int insert_pos(logic [63:0] w, int len);
    int h, downs, seen, i;
    h     = 0;
    downs = 0;
    seen  = 0;
    for (i = 0; i < len; i++) begin
      if (!w[i] && h == 0) downs++;
      h += w[i] ? 1 : -1;
    end
    h = 0;
    for (i = 0; i < len; i++) begin
      if (!w[i] && (h == 0 || h == 1)) begin
        seen++;
        if (seen == downs + 1) return i;
      end
      h += w[i] ? 1 : -1;
    end
    return -1;
  endfunction

  // (count of ups from height 1)-th up step starting at height 0 or 1
  function automatic int delete_pos(logic [63:0] w, int len);
    int h, ups, seen, i;
    h    = 0;
    ups  = 0;
    seen = 0;
    for (i = 0; i < len; i++) begin
      if (w[i] && h == 1) ups++;
      h += w[i] ? 1 : -1;
    end
    h = 0;
    for (i = 0; i < len; i++) begin
      if (w[i] && (h == 0 || h == 1)) begin
        seen++;
        if (seen == ups) return i;
      end
      h += w[i] ? 1 : -1;
    end
    return -1;
  endfunction

  function automatic void predict_rounds(logic [dwfr_pkg::ROOT_W-1:0] root,
                                         logic [dwfr_pkg::HALF_W-1:0] half_raw);
    logic [63:0] word;
    int          m, ins, del, j;
    round_rep_t  rep;
    // steps past bit 31 read as down
    word = 64'(root);
    if (half_raw == 0) m = 1;
    else if (half_raw > MAX_HALF_LENGTH) m = MAX_HALF_LENGTH;
    else m = int'(half_raw);
    for (j = 0; j < m; j++) begin
      rep.rank = dwfr_pkg::RANK_W'(j + 1);
      ins = insert_pos(word, 2 * m);
      if (ins < 0) begin
        rep.ins_pos = '0;
        rep.del_pos = '0;
        rep.fault   = 1'b1;
        rep.last    = 1'b1;
        expected_rounds.insert(expected_rounds.size(), rep);
        return;
      end
      word[ins]   = 1'b1;
      rep.ins_pos = dwfr_pkg::POS_W'(ins);
      del = delete_pos(word, 2 * m);
      if (del < 0) begin
        rep.del_pos = '0;
        rep.fault   = 1'b1;
        rep.last    = 1'b1;
        expected_rounds.insert(expected_rounds.size(), rep);
        return;
      end
      word[del]   = 1'b0;
      rep.del_pos = dwfr_pkg::POS_W'(del);
      rep.fault   = 1'b0;
      rep.last    = (j == m - 1);
      expected_rounds.insert(expected_rounds.size(), rep);
    end
  endfunction

  function automatic void compare_field(string field, logic [4:0] want_v, logic [4:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_cfg  <= dwfr_pkg::HALF_RESET;
      pending_o <= 0;
      expected_rounds.delete();
    end else begin
      if (cfg_we_i) half_cfg <= cfg_wdata_i;
      // retire before predicting so a same-edge word never meets its own reports
      if (out_valid_i && !out_stall_i) begin
        rounds_seen++;
        if (fault_i === 1'b1) faults_seen++;
        if (expected_rounds.size() == 0) begin
          mismatches++;
          $display("%0t: round report with nothing expected, expected none, actual %0d/%0d/%0d",
                   $time, insert_position_i, delete_position_i, round_rank_i);
        end else begin
          want = expected_rounds.pop_front();
          compare_field("insert_position", want.ins_pos, insert_position_i);
          compare_field("delete_position", want.del_pos, delete_position_i);
          compare_field("round_rank", want.rank, round_rank_i);
          compare_field("fault", 5'(want.fault), 5'(fault_i));
          compare_field("last", 5'(want.last), 5'(last_i));
        end
      end
      if (in_valid_i && !in_stall_i) predict_rounds(root_word_i, half_cfg);
      pending_o <= expected_rounds.size();
    end
  end

endmodule

// File: bench/tb_dyck_word_flip_rank_chain.sv
// ---------------------------------------------------------------------------
// tb_dyck_word_flip_rank_chain
// drives root words through the flip rank chain under several half lengths,
// with random idling on both sides and long receiver hold-offs; the checker
// beside the block predicts every round report and counts mismatches
// ---------------------------------------------------------------------------
module tb_dyck_word_flip_rank_chain;

  localparam int MAX_HALF     = 16;
  localparam int LIMIT        = 1_000_000;
  localparam int HOLD_CYCLES  = 700;
  localparam int IDLE_PCT     = 37;
  localparam int RANDOM_WORDS = 420;
  localparam int PHASES       = 8;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [dwfr_pkg::HALF_W-1:0]   cfg_wdata_i = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  logic [dwfr_pkg::ROOT_W-1:0]   root_word_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [dwfr_pkg::POS_W-1:0]    insert_position_o;
  logic [dwfr_pkg::POS_W-1:0]    delete_position_o;
  logic [dwfr_pkg::RANK_W-1:0]   round_rank_o;
  logic                          fault_o;
  logic                          last_o;

  logic                          quiet       = 1'b0;
  int                            hold_ask    = 0;
  int                            hold_seen   = 0;
  int                            hold_left   = 0;
  int                            cycle_count = 0;
  int                            words_sent  = 0;
  int                            settings_used = 0;
  int                            eff_half    = int'(dwfr_pkg::HALF_RESET);
  int                            pending, fail_count, rounds_checked, faults_seen;
  int                            p;
  logic [dwfr_pkg::HALF_W-1:0]   phase_half;

  dyck_word_flip_rank_chain #(
    .MAX_HALF_LENGTH(MAX_HALF)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .root_word_i      (root_word_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .insert_position_o(insert_position_o),
    .delete_position_o(delete_position_o),
    .round_rank_o     (round_rank_o),
    .fault_o          (fault_o),
    .last_o           (last_o)
  );

  dwfr_checker #(
    .MAX_HALF_LENGTH(MAX_HALF)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .root_word_i      (root_word_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .insert_position_i(insert_position_o),
    .delete_position_i(delete_position_o),
    .round_rank_i     (round_rank_o),
    .fault_i          (fault_o),
    .last_i           (last_o),
    .pending_o        (pending),
    .errors_o         (fail_count),
    .rounds_o         (rounds_checked),
    .faults_o         (faults_seen)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("timeout after %0d cycles, %0d round reports still owed", cycle_count, pending);
      $display("tb_dyck_word_flip_rank_chain: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when one is asked for
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_ask != hold_seen) begin
      hold_seen   <= hold_ask;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // valid stays high from one word to the next unless an idle cycle falls between
  task automatic send_word(logic [dwfr_pkg::ROOT_W-1:0] w);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    root_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_half(logic [dwfr_pkg::HALF_W-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (v == 0) eff_half = 1;
    else if (v > MAX_HALF) eff_half = MAX_HALF;
    else eff_half = int'(v);
    settings_used++;
  endtask

  // random balanced word over the low 2m steps, random bits above
  function automatic logic [dwfr_pkg::ROOT_W-1:0] dyck_word(int m);
    logic [dwfr_pkg::ROOT_W-1:0] w;
    int                          h, i;
    w = $urandom();
    h = 0;
    for (i = 0; i < 2 * m; i++) begin
      if (h == 0) w[i] = 1'b1;
      else if (h == 2 * m - i) w[i] = 1'b0;
      else w[i] = $urandom_range(0, 1);
      h += w[i] ? 1 : -1;
    end
    return w;
  endfunction

  // mostly balanced words, some with one step flipped, the rest noise
  task automatic random_words(int count);
    int                          k, r;
    logic [dwfr_pkg::ROOT_W-1:0] w;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        w = dyck_word(eff_half);
      end else if (r < 85) begin
        w = dyck_word(eff_half);
        w[$urandom_range(0, 2 * eff_half - 1)] ^= 1'b1;
      end else begin
        w = $urandom();
      end
      send_word(w);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset half length of 8
    send_word(32'h0000_0000);   // insert finds no match
    send_word(32'hFFFF_FFFF);   // no down steps at all
    send_word(32'h0000_0001);   // delete map sees no up step from height 1
    send_word(32'h0000_5555);
    send_word(32'h0000_00FF);
    send_word(32'hFFFF_0000);   // high garbage, low steps all down

    set_half(5'd16);
    send_word(32'h5555_5555);
    send_word(32'h0000_FFFF);
    send_word(32'hAAAA_AAAA);
    send_word(32'h8000_0000);
    send_word(dyck_word(16));
    send_word(dyck_word(16));

    // zero acts as one
    set_half(5'd0);
    send_word(32'h0000_0001);
    send_word(32'h0000_0002);
    send_word(32'h0000_0000);
    send_word(32'h0000_0003);

    // saturation above the maximum
    set_half(5'd31);
    send_word(32'h5555_5555);
    send_word(32'h0F0F_0F0F);
    send_word(32'hFFFF_FFFE);

    set_half(5'd17);
    send_word(32'h3333_3333);

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       phase_half = 5'd1;
        1:       phase_half = 5'd16;
        2:       phase_half = 5'd4;
        3:       phase_half = dwfr_pkg::HALF_W'($urandom_range(1, 16));
        4:       phase_half = 5'd31;
        5:       phase_half = dwfr_pkg::HALF_W'($urandom_range(0, 31));
        6:       phase_half = 5'd2;
        default: phase_half = dwfr_pkg::HALF_W'($urandom_range(5, 12));
      endcase
      set_half(phase_half);
      quiet <= (p == 3);
      if (p == 1 || p == 6) hold_ask <= hold_ask + 1;
      random_words(RANDOM_WORDS / PHASES);
    end

    drain();
    repeat (300) @(posedge clk_i);
    $display("sent %0d root words across %0d half length settings", words_sent, settings_used);
    $display("checked %0d round reports, %0d of them faults", rounds_checked, faults_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_dyck_word_flip_rank_chain: done, clean");
    end else begin
      $display("tb_dyck_word_flip_rank_chain: done, errors");
    end
    $finish;
  end

endmodule
